FILE: design/tovs_pkg.sv
`timescale 1ns / 1ps

package tovs_pkg;

  // Value format: two's complement with 16 fraction bits.
  localparam int unsigned VW = 32;
  // Control period register width.
  localparam int unsigned CW = 16;
  // Width of three times the period.
  localparam int unsigned TW = CW + 2;
  // Predicted error width.
  localparam int unsigned PW = VW + 2;
  // Square root radicand and root widths.
  localparam int unsigned NW = 2 * VW + 2;
  localparam int unsigned SW = VW + 1;
  // Dividend width for the overshoot clip quotient.
  localparam int unsigned DW = VW + CW;
  // Reset value of the control period.
  localparam logic [CW-1:0] CYCLE_RESET = CW'(328);

  typedef struct packed {
    logic                 command;
    logic signed [VW-1:0] position_error;
    logic signed [VW-1:0] max_velocity;
    logic signed [VW-1:0] current_velocity;
    logic [VW-2:0]        acceleration;
    logic signed [VW-1:0] end_velocity;
  } in_t;

  typedef struct packed {
    logic signed [VW-1:0] velocity_ref;
    logic                 overshoot_clipped;
  } out_t;

  // Item state carried through the square root and divider stages.
  typedef struct packed {
    logic                 cmd;
    logic signed [VW-1:0] err;
    logic [VW-1:0]        cap;
    logic                 pred_pos;
    logic                 pred_neg;
    logic [CW-1:0]        cyc;
    logic [TW-1:0]        tri3;
    logic [NW-1:0]        srem;
    logic [SW-1:0]        root;
    logic [CW-1:0]        drem;
    logic [DW-1:0]        dsh;
  } pipe_t;

endpackage

FILE: design/tovs_front.sv
`timescale 1ns / 1ps

module tovs_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  tovs_pkg::in_t           in_beat_i,
  input  logic [tovs_pkg::CW-1:0] cycle_time_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output tovs_pkg::pipe_t         out_pipe_o
);

  localparam int unsigned VW = tovs_pkg::VW;
  localparam int unsigned CW = tovs_pkg::CW;
  localparam int unsigned TW = tovs_pkg::TW;
  localparam int unsigned PW = tovs_pkg::PW;
  localparam int unsigned NW = tovs_pkg::NW;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // Stage 1 registers.
  logic                    cmd1_q;
  logic signed [VW-1:0]    err1_q;
  logic [VW-1:0]           emag1_q, cap1_q, me1_q, acc2_1_q;
  logic [CW-1:0]           cyc1_q;
  logic [TW-1:0]           tri1_q;
  logic signed [VW+TW:0]   vprod1_q;

  // Stage 2 registers.
  logic                    cmd2_q;
  logic signed [VW-1:0]    err2_q;
  logic [VW-1:0]           emag2_q, cap2_q, me2_q, acc2_2_q;
  logic [CW-1:0]           cyc2_q;
  logic [TW-1:0]           tri2_q;
  logic [PW-2:0]           pmag2_q;
  logic                    ppos2_q, pneg2_q;
  logic [2*VW-1:0]         mae2_q, mesq2_q, capsq2_q;

  tovs_pkg::pipe_t         pipe3_q;

  // Each stage takes a beat when it is empty or its successor moves.
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1: magnitudes, defaults for zero period and acceleration, velocity product.
  logic [CW-1:0]     c_eff;
  logic [TW-1:0]     tri_d;
  logic [VW-2:0]     acc_eff;
  logic signed [VW-1:0] vel;

  always_comb begin
    c_eff   = (cycle_time_i == '0) ? CW'(1) : cycle_time_i;
    tri_d   = {2'b00, c_eff} + {1'b0, c_eff, 1'b0};
    acc_eff = (in_beat_i.acceleration == '0) ? (VW-1)'(1) : in_beat_i.acceleration;
    vel     = in_beat_i.current_velocity;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      cmd1_q   <= in_beat_i.command;
      err1_q   <= in_beat_i.position_error;
      emag1_q  <= in_beat_i.position_error[VW-1] ?
                  (~in_beat_i.position_error + VW'(1)) : in_beat_i.position_error;
      cap1_q   <= in_beat_i.max_velocity[VW-1] ?
                  (~in_beat_i.max_velocity + VW'(1)) : in_beat_i.max_velocity;
      me1_q    <= in_beat_i.end_velocity[VW-1] ?
                  (~in_beat_i.end_velocity + VW'(1)) : in_beat_i.end_velocity;
      acc2_1_q <= {acc_eff, 1'b0};
      cyc1_q   <= c_eff;
      tri1_q   <= tri_d;
      vprod1_q <= vel * $signed({1'b0, tri_d});
    end
  end

  // Stage 2: predicted error, sign flip check, products for the mode 1 cap.
  logic signed [VW+TW:0] ahead;
  logic signed [PW-1:0]  pred;
  logic                  flip;

  always_comb begin
    ahead = vprod1_q >>> 17;
    pred  = $signed({{2{err1_q[VW-1]}}, err1_q}) + ahead[PW-1:0];
    flip  = !cmd1_q && ((pred < 0 && err1_q > 0) || (pred > 0 && err1_q < 0));
    if (flip) begin
      pred = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      cmd2_q   <= cmd1_q;
      err2_q   <= err1_q;
      emag2_q  <= emag1_q;
      cap2_q   <= cap1_q;
      me2_q    <= me1_q;
      acc2_2_q <= acc2_1_q;
      cyc2_q   <= cyc1_q;
      tri2_q   <= tri1_q;
      pmag2_q  <= pred[PW-1] ? (PW-1)'(-pred) : pred[PW-2:0];
      ppos2_q  <= pred > 0;
      pneg2_q  <= pred < 0;
      mae2_q   <= acc2_1_q * emag1_q;
      mesq2_q  <= me1_q * me1_q;
      capsq2_q <= cap1_q * cap1_q;
    end
  end

  // Stage 3: square root radicand and the effective speed cap.
  logic [2*VW:0] lhs;
  logic [NW-1:0] rad;
  logic          capsel;

  always_comb begin
    lhs    = {1'b0, mae2_q} + {1'b0, capsq2_q};
    capsel = cmd2_q && (cap2_q < me2_q) && (lhs < {1'b0, mesq2_q});
    rad    = NW'(acc2_2_q * pmag2_q) + (cmd2_q ? NW'(mesq2_q) : NW'(0));
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      pipe3_q.cmd      <= cmd2_q;
      pipe3_q.err      <= err2_q;
      pipe3_q.cap      <= capsel ? me2_q : cap2_q;
      pipe3_q.pred_pos <= ppos2_q;
      pipe3_q.pred_neg <= pneg2_q;
      pipe3_q.cyc      <= cyc2_q;
      pipe3_q.tri3     <= tri2_q;
      pipe3_q.srem     <= rad;
      pipe3_q.root     <= '0;
      pipe3_q.drem     <= '0;
      pipe3_q.dsh      <= {emag2_q, {CW{1'b0}}};
    end
  end

  assign out_valid_o = v3_q;
  assign out_pipe_o  = pipe3_q;

endmodule

FILE: design/tovs_iter.sv
`timescale 1ns / 1ps

module tovs_iter #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tovs_pkg::pipe_t in_pipe_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tovs_pkg::pipe_t out_pipe_o
);

  localparam int unsigned NW      = tovs_pkg::NW;
  localparam int unsigned SW      = tovs_pkg::SW;
  localparam int unsigned CW      = tovs_pkg::CW;
  localparam int unsigned DW      = tovs_pkg::DW;
  localparam bit          DO_SQRT = (STEP < SW);
  localparam int unsigned BIT     = (STEP < SW) ? (SW - 1 - STEP) : 0;

  logic            valid_q;
  tovs_pkg::pipe_t pipe_q;
  tovs_pkg::pipe_t pipe_d;
  logic [NW:0]     trial;
  logic [CW:0]     part;

  assign in_ready_o = !valid_q || out_ready_i;

  // One quotient bit per stage, and one root bit (restoring square root) in each of the first SW stages.
  always_comb begin
    pipe_d = in_pipe_i;
    trial  = ({1'b0, NW'(in_pipe_i.root)} << (BIT + 1)) + ((NW+1)'(1) << (2 * BIT));
    if (DO_SQRT && ({1'b0, in_pipe_i.srem} >= trial)) begin
      pipe_d.srem = in_pipe_i.srem - trial[NW-1:0];
      pipe_d.root = in_pipe_i.root | (SW'(1) << BIT);
    end
    part = {in_pipe_i.drem, in_pipe_i.dsh[DW-1]};
    if (part >= {1'b0, in_pipe_i.cyc}) begin
      pipe_d.drem = CW'(part - {1'b0, in_pipe_i.cyc});
      pipe_d.dsh  = {in_pipe_i.dsh[DW-2:0], 1'b1};
    end else begin
      pipe_d.drem = part[CW-1:0];
      pipe_d.dsh  = {in_pipe_i.dsh[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      pipe_q <= pipe_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_pipe_o  = pipe_q;

endmodule

FILE: design/tovs_back.sv
`timescale 1ns / 1ps

module tovs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tovs_pkg::pipe_t in_pipe_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tovs_pkg::out_t  out_beat_o
);

  localparam int unsigned VW = tovs_pkg::VW;
  localparam int unsigned TW = tovs_pkg::TW;
  localparam int unsigned SW = tovs_pkg::SW;
  localparam int unsigned DW = tovs_pkg::DW;
  localparam int unsigned PW = tovs_pkg::PW;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic                   cmd1_q, cmd2_q;
  logic signed [VW-1:0]   err1_q, err2_q;
  logic [TW-1:0]          tri1_q;
  logic [DW-1:0]          quo1_q, quo2_q;
  logic signed [VW:0]     ref1_q, ref2_q;
  logic signed [VW+TW+1:0] rprod2_q;
  tovs_pkg::out_t         beat3_q;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1: cap the root and point it against the predicted error.
  logic [SW-1:0]      speed;
  logic signed [VW:0] ref_d;

  always_comb begin
    speed = (in_pipe_i.root > SW'(in_pipe_i.cap)) ? SW'(in_pipe_i.cap) : in_pipe_i.root;
    if (in_pipe_i.pred_pos) begin
      ref_d = -$signed(speed);
    end else if (in_pipe_i.pred_neg || in_pipe_i.cmd) begin
      ref_d = $signed(speed);
    end else begin
      ref_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      cmd1_q <= in_pipe_i.cmd;
      err1_q <= in_pipe_i.err;
      tri1_q <= in_pipe_i.tri3;
      quo1_q <= in_pipe_i.dsh;
      ref1_q <= ref_d;
    end
  end

  // Stage 2: distance covered in 1.5 cycles at the new reference.
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      cmd2_q   <= cmd1_q;
      err2_q   <= err1_q;
      quo2_q   <= quo1_q;
      ref2_q   <= ref1_q;
      rprod2_q <= ref1_q * $signed({1'b0, tri1_q});
    end
  end

  // Stage 3: overshoot check, clip value and saturation.
  logic signed [VW+TW+1:0] ahead;
  logic signed [PW:0]      chk;
  logic                    clip;
  logic [VW-1:0]           dlim;
  logic signed [VW:0]      cref;
  logic signed [VW:0]      fin;
  logic signed [VW-1:0]    sat;

  always_comb begin
    ahead = rprod2_q >>> 17;
    chk   = $signed({{3{err2_q[VW-1]}}, err2_q}) + ahead[PW:0];
    clip  = !cmd2_q && ((chk < 0 && err2_q > 0) || (chk > 0 && err2_q < 0));
    dlim  = (quo2_q > DW'({1'b1, {(VW-1){1'b0}}})) ? {1'b1, {(VW-1){1'b0}}}
                                                   : quo2_q[VW-1:0];
    cref  = (err2_q > 0) ? -$signed({1'b0, dlim}) : $signed({1'b0, dlim});
    fin   = clip ? cref : ref2_q;
    if (fin > $signed({2'b00, {(VW-1){1'b1}}})) begin
      sat = {1'b0, {(VW-1){1'b1}}};
    end else if (fin < $signed({2'b11, {(VW-1){1'b0}}})) begin
      sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat = fin[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      beat3_q.velocity_ref      <= sat;
      beat3_q.overshoot_clipped <= clip;
    end
  end

  assign out_valid_o = v3_q;
  assign out_beat_o  = beat3_q;

endmodule

FILE: design/time_optimal_velocity_servo_core.sv
`timescale 1ns / 1ps

// Channel     Direction  Handshake                  Beat
// ---------   ---------  -------------------------  ---------------------
// input       in         in_valid_i / in_ready_o    tovs_pkg::in_t
// result      out        out_valid_o / out_ready_i  tovs_pkg::out_t
// cycle_time  in         cycle_time_we_i            16-bit period word
//
// One beat enters per cycle while in_ready_o is high. The depth is set by the
// one-bit-per-stage quotient of the clip divider. Three front stages, DW
// divider/square root stages and three back stages.
// Reset clears all valid bits and loads cycle_time with 328.
// Every stage holds its beat while its successor is full and stalled, so a
// stall at the output fills bubbles before it backs up to in_ready_o.

module time_optimal_velocity_servo_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  tovs_pkg::in_t           in_beat_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output tovs_pkg::out_t          out_beat_o,
  input  logic                    cycle_time_we_i,
  input  logic [tovs_pkg::CW-1:0] cycle_time_i
);

  localparam int unsigned DW = tovs_pkg::DW;

  logic [tovs_pkg::CW-1:0] cycle_q;
  logic                    valid_s [DW+1];
  logic                    ready_s [DW+1];
  tovs_pkg::pipe_t         pipe_s  [DW+1];

  // Control period register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= tovs_pkg::CYCLE_RESET;
    end else if (cycle_time_we_i) begin
      cycle_q <= cycle_time_i;
    end
  end

  tovs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .cycle_time_i (cycle_q),
    .out_valid_o  (valid_s[0]),
    .out_ready_i  (ready_s[0]),
    .out_pipe_o   (pipe_s[0])
  );

  // Square root and clip divider stages.
  for (genvar k = 0; k < DW; k++) begin : g_iter
    tovs_iter #(
      .STEP (k)
    ) u_iter (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_s[k]),
      .in_ready_o  (ready_s[k]),
      .in_pipe_i   (pipe_s[k]),
      .out_valid_o (valid_s[k+1]),
      .out_ready_i (ready_s[k+1]),
      .out_pipe_o  (pipe_s[k+1])
    );
  end

  tovs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_s[DW]),
    .in_ready_o  (ready_s[DW]),
    .in_pipe_i   (pipe_s[DW]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
